// ----- src/life_generation_engine_core_defines.svh -----
// Assertion macros for the life generation engine.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LIFE_GENERATION_ENGINE_CORE_DEFINES_SVH
`define LIFE_GENERATION_ENGINE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LGE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lge_pkg.sv -----
// Shared types and constants for the life generation engine.
// No dependencies; used by every module of the block except lge_store.
package lge_pkg;

  localparam int OP_W      = 2;
  localparam int ROWIDX_W  = 6;
  localparam int CELLS_W   = 64;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W     = 4;

  // B3/S23
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ROW = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // One column of the three-row window as seen by a neighbouring lane
  typedef struct packed {
    logic above;
    logic here;
    logic below;
  } col_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } lane_ctl_t;

endpackage

// ----- src/lge_cell.sv -----
// One column lane: holds the old cells above and at the current row.
// Depends on lge_pkg.
module lge_cell (
  input  logic               clk,
  input  lge_pkg::lane_ctl_t ctl,
  input  logic               below_i,
  input  lge_pkg::col_t      left_i,
  input  lge_pkg::col_t      right_i,
  output lge_pkg::col_t      col_o,
  output logic               next_o
);

  logic                      above_r;
  logic                      here_r;
  logic [lge_pkg::NBR_W-1:0] nbr_cnt;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      above_r <= 1'b0;
      here_r  <= 1'b0;
    end else if (ctl.shift) begin
      above_r <= here_r;
      here_r  <= below_i;
    end
  end

  assign col_o = '{above: above_r, here: here_r, below: below_i};

  assign nbr_cnt = lge_pkg::NBR_W'(left_i.above) + lge_pkg::NBR_W'(left_i.here)
                 + lge_pkg::NBR_W'(left_i.below) + lge_pkg::NBR_W'(above_r)
                 + lge_pkg::NBR_W'(below_i) + lge_pkg::NBR_W'(right_i.above)
                 + lge_pkg::NBR_W'(right_i.here) + lge_pkg::NBR_W'(right_i.below);

  assign next_o = (nbr_cnt == lge_pkg::BIRTH_COUNT)
               || (here_r && (nbr_cnt == lge_pkg::SURVIVE_COUNT));

endmodule

// ----- src/lge_lanes.sv -----
// Row of column lanes; each lane trades its window column with both neighbours.
// Depends on lge_pkg and lge_cell.
module lge_lanes #(
  parameter int MAX_COLS = 64
) (
  input  logic                clk,
  input  lge_pkg::lane_ctl_t  ctl,
  input  logic [MAX_COLS-1:0] below_i,
  output logic [MAX_COLS-1:0] next_o
);

  lge_pkg::col_t col [MAX_COLS];

  for (genvar gi = 0; gi < MAX_COLS; gi++) begin : g_lane
    lge_pkg::col_t left_c;
    lge_pkg::col_t right_c;

    // cells past either edge are dead
    if (gi == 0) begin : g_left_edge
      assign left_c = '0;
    end else begin : g_left
      assign left_c = col[gi-1];
    end

    if (gi == MAX_COLS - 1) begin : g_right_edge
      assign right_c = '0;
    end else begin : g_right
      assign right_c = col[gi+1];
    end

    lge_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .below_i (below_i[gi]),
      .left_i  (left_c),
      .right_i (right_c),
      .col_o   (col[gi]),
      .next_o  (next_o[gi])
    );
  end

endmodule

// ----- src/lge_store.sv -----
// Row store: one word per grid row, one write and one registered read a cycle.
// Per-row valid bits stand in for clearing the array at reset. No dependencies.
module lge_store #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_ROWS)-1:0] wr_addr,
  input  logic [MAX_COLS-1:0]         wr_data,
  input  logic [$clog2(MAX_ROWS)-1:0] rd_addr,
  output logic [MAX_COLS-1:0]         rd_data_r,
  output logic                        rd_valid_r
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= row_valid_r[rd_addr];
    end
  end

endmodule

// ----- src/life_generation_engine_core.sv -----
// Life generation engine top level (B3/S23, non-wrapping edges).
// Depends on lge_pkg, lge_store, lge_lanes and the assertion macro header.
//
//  channel  | direction | signals                                        | request
//  ---------+-----------+------------------------------------------------+-----------------
//  in_      | in        | in_valid, in_stall, operation/row_index/cells | one operation
//  out_     | out       | out_valid, out_stall, row_cells_out/status    | one result
//  cfg_     | in        | cfg_wr_en, cfg_index, cfg_wdata                | register write
//
// Write and unused codes answer at the accepting edge; a read answers at the next edge.
// An advance walks the lane row over the grid one row per cycle
// through the single read port of the row store.
// Reset is synchronous; per-row valid bits make the grid read dead at once, no sweep.
// One request is in flight at a time; a new one is taken only while the output
// register is empty or is being drained at that same edge.
`include "life_generation_engine_core_defines.svh"

module life_generation_engine_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lge_pkg::OP_W-1:0]             in_operation,
  input  logic [lge_pkg::ROWIDX_W-1:0]         in_row_index,
  input  logic [lge_pkg::CELLS_W-1:0]          in_row_cells,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lge_pkg::CELLS_W-1:0]          out_row_cells_out,
  output logic                                 out_status,
  input  logic                                 cfg_wr_en,
  input  logic [lge_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lge_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 2);
  localparam int CMP_W  = CNT_W + lge_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_ADV  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       in_range_r, in_range_nxt;
  logic                       rd_bad_r, rd_bad_nxt;

  logic [lge_pkg::CFG_W-1:0]  grid_width_r;
  logic [lge_pkg::CFG_W-1:0]  grid_height_r;
  logic [lge_pkg::CFG_W-1:0]  w_use;
  logic [CMP_W-1:0]           h_ext, h_clamp;
  logic [CNT_W-1:0]           h_use;
  logic [MAX_COLS-1:0]        col_mask;
  logic                       row_bad;
  logic                       in_accept;

  logic                       st_wr_en;
  logic [ROW_AW-1:0]          st_wr_addr;
  logic [MAX_COLS-1:0]        st_wr_data;
  logic [ROW_AW-1:0]          st_rd_addr;
  logic [MAX_COLS-1:0]        st_rd_data;
  logic                       st_rd_valid;

  lge_pkg::lane_ctl_t         ln_ctl;
  logic [MAX_COLS-1:0]        ln_below;
  logic [MAX_COLS-1:0]        ln_next;

  logic                       out_load;
  logic [lge_pkg::CELLS_W-1:0] out_cells_nxt;
  logic                       out_status_nxt;
  logic                       out_valid_r;
  logic [lge_pkg::CELLS_W-1:0] out_cells_r;
  logic                       out_status_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lge_pkg::GRID_WIDTH_RST;
      grid_height_r <= lge_pkg::GRID_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == lge_pkg::REG_GRID_WIDTH) begin
        grid_width_r <= cfg_wdata;
      end
      if (cfg_index == lge_pkg::REG_GRID_HEIGHT) begin
        grid_height_r <= cfg_wdata;
      end
    end
  end

  // clamp width and height into 1..MAX
  always_comb begin
    if (grid_width_r == '0) begin
      w_use = lge_pkg::CFG_W'(1);
    end else if (grid_width_r > lge_pkg::CFG_W'(MAX_COLS)) begin
      w_use = lge_pkg::CFG_W'(MAX_COLS);
    end else begin
      w_use = grid_width_r;
    end

    h_ext = CMP_W'(grid_height_r);
    if (h_ext == '0) begin
      h_clamp = CMP_W'(1);
    end else if (h_ext > CMP_W'(MAX_ROWS)) begin
      h_clamp = CMP_W'(MAX_ROWS);
    end else begin
      h_clamp = h_ext;
    end
    h_use = CNT_W'(h_clamp);

    for (int x = 0; x < MAX_COLS; x++) begin
      col_mask[x] = (lge_pkg::CFG_W'(x) < w_use);
    end
  end

  assign row_bad   = (CMP_W'(in_row_index) >= h_clamp);
  assign in_stall  = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_accept = in_valid && !in_stall;

  // rows outside the height, never-written rows and cells beyond the width are dead
  assign ln_below = (in_range_r && st_rd_valid) ? (st_rd_data & col_mask) : '0;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    in_range_nxt   = 1'b0;
    rd_bad_nxt     = rd_bad_r;
    st_wr_en       = 1'b0;
    st_wr_addr     = ROW_AW'(in_row_index);
    st_wr_data     = in_row_cells[MAX_COLS-1:0] & col_mask;
    st_rd_addr     = ROW_AW'(in_row_index);
    ln_ctl         = '0;
    out_load       = 1'b0;
    out_cells_nxt  = '0;
    out_status_nxt = lge_pkg::STATUS_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (lge_pkg::op_t'(in_operation))
            lge_pkg::OP_WRITE: begin
              st_wr_en       = !row_bad;
              out_load       = 1'b1;
              out_status_nxt = row_bad;
            end
            lge_pkg::OP_READ: begin
              rd_bad_nxt = row_bad;
              state_nxt  = ST_READ;
            end
            lge_pkg::OP_ADVANCE: begin
              ln_ctl.clear = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = ST_ADV;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load       = 1'b1;
        out_status_nxt = rd_bad_r;
        if (!rd_bad_r && st_rd_valid) begin
          out_cells_nxt = lge_pkg::CELLS_W'(st_rd_data & col_mask);
        end
        state_nxt = ST_IDLE;
      end
      ST_ADV: begin
        // fetch row cnt, slide the window with row cnt-1, retire row cnt-2
        st_rd_addr   = ROW_AW'(cnt_r);
        in_range_nxt = (cnt_r < h_use);
        ln_ctl.shift = (cnt_r != '0);
        if (cnt_r >= CNT_W'(2)) begin
          st_wr_en   = 1'b1;
          st_wr_addr = ROW_AW'(cnt_r - CNT_W'(2));
          st_wr_data = ln_next & col_mask;
        end
        if (cnt_r == h_use + CNT_W'(1)) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      in_range_r <= 1'b0;
      rd_bad_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      in_range_r <= in_range_nxt;
      rd_bad_r   <= rd_bad_nxt;
    end
  end

  lge_store #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (st_wr_en),
    .wr_addr    (st_wr_addr),
    .wr_data    (st_wr_data),
    .rd_addr    (st_rd_addr),
    .rd_data_r  (st_rd_data),
    .rd_valid_r (st_rd_valid)
  );

  lge_lanes #(
    .MAX_COLS (MAX_COLS)
  ) u_lanes (
    .clk     (clk),
    .ctl     (ln_ctl),
    .below_i (ln_below),
    .next_o  (ln_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cells_r  <= out_cells_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_cells_out = out_cells_r;
  assign out_status        = out_status_r;

  `LGE_ASSERT_SAME(a_out_slot_free, out_load, (!out_valid_r || !out_stall), "result overwritten")
  `LGE_ASSERT_SAME(a_adv_wr_in_grid, (st_wr_en && (state_r == ST_ADV)), ((cnt_r - CNT_W'(2)) < h_use), "advance wrote past height")
  `LGE_ASSERT_NEXT(a_read_answers, (in_accept && (in_operation == lge_pkg::OP_READ)), out_load, "read gave no result")

endmodule
